### rtl/core/mvrl_pkg.sv
// ----------------------------------------------------------------------------
// mvrl_pkg
// Shared types, codes and tables for the mono voice control block.
// ----------------------------------------------------------------------------
package mvrl_pkg;

    // Input beat
    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  note;
        logic [10:0] velocity;
    } mvrl_in_t;

    // Result beat
    typedef struct packed {
        logic [17:0] main_freq;
        logic [17:0] detuned_freq;
        logic [16:0] sub_freq;
        logic [9:0]  amp_gain;
        logic [12:0] cutoff_hz;
        logic [12:0] filter_q;
        logic        voice_on;
        logic        in_release;
        logic [7:0]  playing_note;
    } mvrl_out_t;

    // Serial arithmetic unit widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 17;
    localparam int MUL_C_W = 5;
    localparam int DIV_N_W = 28;
    localparam int DIV_D_W = 13;
    localparam int DIV_C_W = 5;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mvrl_mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_A_W-1:0] p;
    } mvrl_mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } mvrl_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } mvrl_div_rsp_t;

    // Event codes
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;
    localparam logic [1:0] FUNC_TICK     = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_CUTOFF_BASE = 3'd0;
    localparam logic [2:0] REG_RESONANCE   = 3'd1;
    localparam logic [2:0] REG_LFO_RATE    = 3'd2;
    localparam logic [2:0] REG_LFO_DEPTH   = 3'd3;
    localparam logic [2:0] REG_DETUNE      = 3'd4;

    localparam logic [7:0] NO_NOTE = 8'd128;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PEAK_DIV,
        ST_TICK,
        ST_REL_MUL,
        ST_REL_DIV,
        ST_LFO,
        ST_INC_MUL,
        ST_INC_DIV,
        ST_IDX_MUL,
        ST_Z_DIV,
        ST_Z2_MUL,
        ST_T1_MUL,
        ST_T2_MUL,
        ST_S_MUL,
        ST_M1_MUL,
        ST_M2_MUL,
        ST_M3_MUL,
        ST_CB_MUL,
        ST_RQ_MUL,
        ST_Q_DIV,
        ST_DET_MUL,
        ST_OUT
    } mvrl_state_t;

    // Octave-reduced note frequencies, 7040 Hz * 2048 scale
    function automatic logic [23:0] semitone(input logic [3:0] k);
        logic [23:0] v;
        case (k)
            4'd0:    v = 24'd8572947;
            4'd1:    v = 24'd9082720;
            4'd2:    v = 24'd9622807;
            4'd3:    v = 24'd10195009;
            4'd4:    v = 24'd10801236;
            4'd5:    v = 24'd11443511;
            4'd6:    v = 24'd12123977;
            4'd7:    v = 24'd12844906;
            4'd8:    v = 24'd13608704;
            4'd9:    v = 24'd14417920;
            4'd10:   v = 24'd15275254;
            4'd11:   v = 24'd16183568;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // Octave of a MIDI note: count of twelve-step thresholds passed
    function automatic logic [3:0] note_octave(input logic [6:0] n);
        logic [3:0] o;
        o = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (n >= 7'(12 * i)) begin
                o = 4'(i);
            end
        end
        return o;
    endfunction

endpackage

### rtl/core/mvrl_ser_mul.sv
// ----------------------------------------------------------------------------
// mvrl_ser_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mvrl_ser_mul import mvrl_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  mvrl_mul_req_t req,
    output mvrl_mul_rsp_t rsp
);

    logic [MUL_A_W-1:0] acc_reg, acc_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [MUL_C_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            cnt_next  = MUL_C_W'(MUL_B_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[MUL_A_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[MUL_B_W-1:1]};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

### rtl/core/mvrl_ser_div.sv
// ----------------------------------------------------------------------------
// mvrl_ser_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvrl_ser_div import mvrl_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  mvrl_div_req_t req,
    output mvrl_div_rsp_t rsp
);

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] num_reg, num_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_C_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign trial = {rem_reg, num_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            cnt_next  = DIV_C_W'(DIV_N_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            num_next = {num_reg[DIV_N_W-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

### rtl/core/mono_voice_release_lfo_filter.sv
// ----------------------------------------------------------------------------
// mono_voice_release_lfo_filter
// Monophonic voice control: note events, linear release, LFO-swept filter.
// ----------------------------------------------------------------------------
// One event beat in, one result beat out. Events are handled one at a time by
// a sequencer that drives a shared bit-serial multiplier and a shared
// bit-serial divider. A note on also computes the peak gain, and a tick while
// releasing recomputes the release gain. A tick that steps the LFO also
// computes the phase increment, plus the sine and filter chain when the voice
// is sounding.
// The next event is taken as soon as the sequencer is back in idle, even if
// the previous result still waits in the output register. Configuration goes
// over the APB port at byte address 4*index and is read back unclamped.
// ----------------------------------------------------------------------------
module mono_voice_release_lfo_filter import mvrl_pkg::*; #(
    parameter int RELEASE_MS       = 50,
    parameter int LFO_INTERVAL_MS  = 10,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mvrl_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output mvrl_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EL_W  = $clog2(RELEASE_MS + 2);
    localparam int TC_W  = $clog2(LFO_INTERVAL_MS + 1);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int Q4_W  = IDX_W + 2;

    // Configuration registers
    logic [10:0] cutoff_base_reg;
    logic [10:0] resonance_reg;
    logic [13:0] lfo_rate_reg;
    logic [10:0] lfo_depth_reg;
    logic [16:0] detune_reg;

    // Voice and sequencer state
    mvrl_state_t      state_reg, state_next;
    logic             launched_reg, launched_next;
    mvrl_in_t         in_reg, in_next;
    logic             active_reg, active_next;
    logic             release_reg, release_next;
    logic [7:0]       note_reg, note_next;
    logic [9:0]       peak_reg, peak_next;
    logic [17:0]      base_reg, base_next;
    logic [9:0]       gain_reg, gain_next;
    logic [EL_W-1:0]  elapsed_reg, elapsed_next;
    logic [15:0]      phase_reg, phase_next;
    logic [TC_W-1:0]  tick_reg, tick_next;
    logic [12:0]      cutoff_reg, cutoff_next;
    logic [12:0]      q_reg, q_next;
    logic [1:0]       quad_reg, quad_next;
    logic [Q4_W-1:0]  rem_reg, rem_next;
    logic [15:0]      z_reg, z_next;
    logic [15:0]      z2_reg, z2_next;
    logic [15:0]      t_reg, t_next;
    logic [21:0]      mag_reg, mag_next;
    logic [17:0]      det_reg, det_next;
    logic             m_valid_reg, m_valid_next;
    mvrl_out_t        m_data_reg, m_data_next;

    mvrl_mul_req_t mul_req;
    mvrl_mul_rsp_t mul_rsp;
    mvrl_div_req_t div_req;
    mvrl_div_rsp_t div_rsp;

    // Clamped register views
    logic [10:0] c_cl, r_cl, d_cl;
    logic [13:0] rate_cl;
    logic [16:0] ratio_cl;

    assign c_cl    = (cutoff_base_reg > 11'd1024) ? 11'd1024 : cutoff_base_reg;
    assign r_cl    = (resonance_reg > 11'd1024) ? 11'd1024 : resonance_reg;
    assign d_cl    = (lfo_depth_reg > 11'd1024) ? 11'd1024 : lfo_depth_reg;
    assign rate_cl = (lfo_rate_reg > 14'd10240) ? 14'd10240 : lfo_rate_reg;
    assign ratio_cl = (detune_reg < 17'd61858) ? 17'd61858 :
                      ((detune_reg > 17'd69433) ? 17'd69433 : detune_reg);

    // Note to base frequency: octave-reduced entry shifted up by the octave
    logic [3:0]  nb_oct;
    logic [3:0]  nb_k;
    logic [34:0] nb_sum;

    assign nb_oct = note_octave(s_data.note);
    assign nb_k   = 4'(s_data.note - 7'(nb_oct * 4'd12));
    assign nb_sum = (35'(semitone(nb_k)) << nb_oct) + 35'd32768;

    // Sine quadrant split of the scaled phase
    logic [IDX_W-1:0] idx_w;
    logic [Q4_W-1:0]  q4_w;
    logic [1:0]       quad_w;
    logic [Q4_W-1:0]  rem_w;

    assign idx_w = mul_rsp.p[16 +: IDX_W];
    assign q4_w  = {idx_w, 2'b00};

    always_comb begin
        if (q4_w >= Q4_W'(3 * SINE_TABLE_DEPTH)) begin
            quad_w = 2'd3;
            rem_w  = q4_w - Q4_W'(3 * SINE_TABLE_DEPTH);
        end else if (q4_w >= Q4_W'(2 * SINE_TABLE_DEPTH)) begin
            quad_w = 2'd2;
            rem_w  = q4_w - Q4_W'(2 * SINE_TABLE_DEPTH);
        end else if (q4_w >= Q4_W'(SINE_TABLE_DEPTH)) begin
            quad_w = 2'd1;
            rem_w  = q4_w - Q4_W'(SINE_TABLE_DEPTH);
        end else begin
            quad_w = 2'd0;
            rem_w  = q4_w;
        end
    end

    // Cutoff: base plus or minus LFO swing, clamp, round to whole hertz
    logic [24:0] cb_sum;
    logic [25:0] tot_w;
    logic [22:0] tot_cl;
    logic [23:0] cut_sum;
    logic        mag_neg_w;

    assign mag_neg_w = quad_reg[1];

    assign cb_sum = 25'd102400 + mul_rsp.p[24:0];
    assign tot_w  = mag_neg_w ? ({1'b0, cb_sum} - 26'(mag_reg))
                              : ({1'b0, cb_sum} + 26'(mag_reg));

    always_comb begin
        if (tot_w[25] || (tot_w < 26'd102400)) begin
            tot_cl = 23'd102400;
        end else if (tot_w > 26'd8192000) begin
            tot_cl = 23'd8192000;
        end else begin
            tot_cl = tot_w[22:0];
        end
    end

    assign cut_sum = {1'b0, tot_cl} + 24'd512;

    // Detuned oscillator: round and saturate
    logic [35:0] det_sum;
    logic [19:0] det_q;
    logic [17:0] det_w;

    assign det_sum = mul_rsp.p[35:0] + 36'd32768;
    assign det_q   = det_sum[35:16];
    assign det_w   = (det_q > 20'd262143) ? 18'h3FFFF : det_q[17:0];

    // Release step
    logic [EL_W-1:0] el_inc;
    assign el_inc = (elapsed_reg <= EL_W'(RELEASE_MS)) ? (elapsed_reg + 1'b1) : elapsed_reg;

    logic [TC_W-1:0] tick_inc;
    assign tick_inc = tick_reg + 1'b1;

    logic [15:0] zq;
    assign zq = div_rsp.quo[15:0];

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        in_next       = in_reg;
        active_next   = active_reg;
        release_next  = release_reg;
        note_next     = note_reg;
        peak_next     = peak_reg;
        base_next     = base_reg;
        gain_next     = gain_reg;
        elapsed_next  = elapsed_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        cutoff_next   = cutoff_reg;
        q_next        = q_reg;
        quad_next     = quad_reg;
        rem_next      = rem_reg;
        z_next        = z_reg;
        z2_next       = z2_reg;
        t_next        = t_reg;
        mag_next      = mag_reg;
        det_next      = det_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        mul_req       = '0;
        div_req       = '0;

        // drop the result once the consumer takes the beat
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    unique case (s_data.func)
                        FUNC_NOTE_ON: begin
                            if ((s_data.velocity != 11'd0) &&
                                (s_data.velocity <= 11'd1024)) begin
                                active_next  = 1'b1;
                                release_next = 1'b0;
                                elapsed_next = '0;
                                note_next    = {1'b0, s_data.note};
                                base_next    = nb_sum[33:16];
                                state_next   = ST_PEAK_DIV;
                            end else begin
                                state_next = ST_DET_MUL;
                            end
                        end
                        FUNC_NOTE_OFF: begin
                            if (active_reg && !release_reg &&
                                (note_reg == {1'b0, s_data.note})) begin
                                release_next = 1'b1;
                                elapsed_next = '0;
                            end
                            state_next = ST_DET_MUL;
                        end
                        FUNC_ALL_OFF: begin
                            if (active_reg && !release_reg) begin
                                release_next = 1'b1;
                                elapsed_next = '0;
                            end
                            state_next = ST_DET_MUL;
                        end
                        FUNC_TICK: begin
                            state_next = ST_TICK;
                        end
                        default: state_next = ST_DET_MUL;
                    endcase
                end
            end
            ST_PEAK_DIV: begin
                // peak gain = (4v + 2) / 5
                div_req.start = !launched_reg;
                div_req.num   = DIV_N_W'({in_reg.velocity, 2'b10});
                div_req.den   = DIV_D_W'(5);
                launched_next = 1'b1;
                if (div_rsp.done) begin
                    launched_next = 1'b0;
                    peak_next     = div_rsp.quo[9:0];
                    gain_next     = div_rsp.quo[9:0];
                    state_next    = ST_DET_MUL;
                end
            end
            ST_TICK: begin
                state_next = ST_LFO;
                if (active_reg && release_reg) begin
                    elapsed_next = el_inc;
                    if (el_inc > EL_W'(RELEASE_MS)) begin
                        gain_next    = '0;
                        active_next  = 1'b0;
                        release_next = 1'b0;
                        note_next    = NO_NOTE;
                    end else begin
                        state_next = ST_REL_MUL;
                    end
                end
            end
            ST_REL_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(peak_reg);
                mul_req.b     = MUL_B_W'(RELEASE_MS) - MUL_B_W'(elapsed_reg);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_REL_DIV;
                end
            end
            ST_REL_DIV: begin
                div_req.start = !launched_reg;
                div_req.num   = mul_rsp.p[DIV_N_W-1:0];
                div_req.den   = DIV_D_W'(RELEASE_MS);
                launched_next = 1'b1;
                if (div_rsp.done) begin
                    launched_next = 1'b0;
                    gain_next     = div_rsp.quo[9:0];
                    state_next    = ST_LFO;
                end
            end
            ST_LFO: begin
                if (tick_inc >= TC_W'(LFO_INTERVAL_MS)) begin
                    tick_next  = '0;
                    state_next = ST_INC_MUL;
                end else begin
                    tick_next  = tick_inc;
                    state_next = ST_DET_MUL;
                end
            end
            ST_INC_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(rate_cl);
                mul_req.b     = MUL_B_W'(LFO_INTERVAL_MS * 64);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_INC_DIV;
                end
            end
            ST_INC_DIV: begin
                div_req.start = !launched_reg;
                div_req.num   = mul_rsp.p[DIV_N_W-1:0] + DIV_N_W'(500);
                div_req.den   = DIV_D_W'(1000);
                launched_next = 1'b1;
                if (div_rsp.done) begin
                    launched_next = 1'b0;
                    phase_next    = phase_reg + div_rsp.quo[15:0];
                    state_next    = active_reg ? ST_IDX_MUL : ST_DET_MUL;
                end
            end
            ST_IDX_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(phase_reg);
                mul_req.b     = MUL_B_W'(SINE_TABLE_DEPTH);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    quad_next     = quad_w;
                    rem_next      = rem_w;
                    state_next    = ST_Z_DIV;
                end
            end
            ST_Z_DIV: begin
                div_req.start = !launched_reg;
                div_req.num   = DIV_N_W'({rem_reg, 15'd0});
                div_req.den   = DIV_D_W'(SINE_TABLE_DEPTH);
                launched_next = 1'b1;
                if (div_rsp.done) begin
                    launched_next = 1'b0;
                    // mirror the position in odd quarters
                    z_next        = quad_reg[0] ? (16'h8000 - zq) : zq;
                    state_next    = ST_Z2_MUL;
                end
            end
            ST_Z2_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(z_reg);
                mul_req.b     = MUL_B_W'(z_reg);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    z2_next       = mul_rsp.p[30:15];
                    state_next    = ST_T1_MUL;
                end
            end
            ST_T1_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(z2_reg);
                mul_req.b     = MUL_B_W'(2320);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    t_next        = 16'd21024 - mul_rsp.p[30:15];
                    state_next    = ST_T2_MUL;
                end
            end
            ST_T2_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(z2_reg);
                mul_req.b     = MUL_B_W'(t_reg);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    t_next        = 16'd51472 - mul_rsp.p[30:15];
                    state_next    = ST_S_MUL;
                end
            end
            ST_S_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(z_reg);
                mul_req.b     = MUL_B_W'(t_reg);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_M1_MUL;
                end
            end
            ST_M1_MUL: begin
                // sine magnitude times depth
                mul_req.start = !launched_reg;
                mul_req.a     = {15'd0, mul_rsp.p[MUL_A_W-1:15]};
                mul_req.b     = MUL_B_W'(d_cl);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_M2_MUL;
                end
            end
            ST_M2_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = mul_rsp.p;
                mul_req.b     = MUL_B_W'(c_cl);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_M3_MUL;
                end
            end
            ST_M3_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = mul_rsp.p;
                mul_req.b     = MUL_B_W'(2000);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    mag_next      = 22'((mul_rsp.p + 48'd16777216) >> 25);
                    state_next    = ST_CB_MUL;
                end
            end
            ST_CB_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(c_cl);
                mul_req.b     = MUL_B_W'(7900);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    cutoff_next   = cut_sum[22:10];
                    state_next    = ST_RQ_MUL;
                end
            end
            ST_RQ_MUL: begin
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(r_cl);
                mul_req.b     = MUL_B_W'(43);
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    state_next    = ST_Q_DIV;
                end
            end
            ST_Q_DIV: begin
                // Q = (7168 + 43 r + 5) / 10
                div_req.start = !launched_reg;
                div_req.num   = mul_rsp.p[DIV_N_W-1:0] + DIV_N_W'(7173);
                div_req.den   = DIV_D_W'(10);
                launched_next = 1'b1;
                if (div_rsp.done) begin
                    launched_next = 1'b0;
                    q_next        = div_rsp.quo[12:0];
                    state_next    = ST_DET_MUL;
                end
            end
            ST_DET_MUL: begin
                // hold the detuned frequency aside; the output beat may still wait
                mul_req.start = !launched_reg;
                mul_req.a     = MUL_A_W'(base_reg);
                mul_req.b     = ratio_cl;
                launched_next = 1'b1;
                if (mul_rsp.done) begin
                    launched_next = 1'b0;
                    det_next      = det_w;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free, then load the beat
                if (!m_valid_reg || m_ready) begin
                    m_data_next.main_freq    = base_reg;
                    m_data_next.detuned_freq = det_reg;
                    m_data_next.sub_freq     = base_reg[17:1];
                    m_data_next.amp_gain     = gain_reg;
                    m_data_next.cutoff_hz    = cutoff_reg;
                    m_data_next.filter_q     = q_reg;
                    m_data_next.voice_on     = active_reg;
                    m_data_next.in_release   = release_reg;
                    m_data_next.playing_note = note_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
            active_reg   <= 1'b0;
            release_reg  <= 1'b0;
            note_reg     <= NO_NOTE;
            peak_reg     <= '0;
            base_reg     <= '0;
            gain_reg     <= '0;
            elapsed_reg  <= '0;
            phase_reg    <= '0;
            tick_reg     <= '0;
            cutoff_reg   <= 13'd1000;
            q_reg        <= 13'd717;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            active_reg   <= active_next;
            release_reg  <= release_next;
            note_reg     <= note_next;
            peak_reg     <= peak_next;
            base_reg     <= base_next;
            gain_reg     <= gain_next;
            elapsed_reg  <= elapsed_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            cutoff_reg   <= cutoff_next;
            q_reg        <= q_next;
            m_valid_reg  <= m_valid_next;
        end
        in_reg     <= in_next;
        quad_reg   <= quad_next;
        rem_reg    <= rem_next;
        z_reg      <= z_next;
        z2_reg     <= z2_next;
        t_reg      <= t_next;
        mag_reg    <= mag_next;
        det_reg    <= det_next;
        m_data_reg <= m_data_next;
    end

    // Configuration port
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_base_reg <= 11'd307;
            resonance_reg   <= 11'd307;
            lfo_rate_reg    <= 14'd338;
            lfo_depth_reg   <= 11'd768;
            detune_reg      <= 17'd65121;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_CUTOFF_BASE: cutoff_base_reg <= pwdata[10:0];
                REG_RESONANCE:   resonance_reg   <= pwdata[10:0];
                REG_LFO_RATE:    lfo_rate_reg    <= pwdata[13:0];
                REG_LFO_DEPTH:   lfo_depth_reg   <= pwdata[10:0];
                REG_DETUNE:      detune_reg      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CUTOFF_BASE: prdata = 32'(cutoff_base_reg);
            REG_RESONANCE:   prdata = 32'(resonance_reg);
            REG_LFO_RATE:    prdata = 32'(lfo_rate_reg);
            REG_LFO_DEPTH:   prdata = 32'(lfo_depth_reg);
            REG_DETUNE:      prdata = 32'(detune_reg);
            default:         prdata = 32'd0;
        endcase
    end

    mvrl_ser_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    mvrl_ser_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_release_needs_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.in_release || m_data.voice_on))
        else $error("release flag without active voice");

    a_free_voice_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.voice_on) |->
        ((m_data.playing_note == NO_NOTE) && (m_data.amp_gain == 10'd0)))
        else $error("free voice with note or gain");

    a_cutoff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.cutoff_hz >= 13'd100) && (m_data.cutoff_hz <= 13'd8000)))
        else $error("cutoff out of range");

    a_idle_no_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !launched_reg)
        else $error("arithmetic unit launched while idle");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mono voice control block.
// ----------------------------------------------------------------------------
// Events are queued by the stimulus process, sent by a clocked driver with
// random gaps, and each result beat is checked field by field against a voice
// predictor that runs in step with every accepted event. Register settings
// change between phases over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import mvrl_pkg::*;

    localparam int REL_MS     = 50;
    localparam int LFO_EVERY  = 10;
    localparam int SINE_DEPTH = 256;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_CYC  = 600;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    mvrl_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    mvrl_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mono_voice_release_lfo_filter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers and voice state.
    logic [10:0] cfg_cutoff;
    logic [10:0] cfg_reso;
    logic [13:0] cfg_rate;
    logic [10:0] cfg_depth;
    logic [16:0] cfg_detune;

    logic        v_active;
    logic        v_release;
    logic [7:0]  v_note;
    logic [10:0] v_vel;
    logic [17:0] v_freq;
    logic [9:0]  v_gain;
    logic [5:0]  v_elapsed;
    logic [15:0] v_phase;
    logic [3:0]  v_tick;
    logic [12:0] v_cutoff;
    logic [12:0] v_q;

    mvrl_in_t  pending_events[$];
    mvrl_out_t voice_results[$];

    int  errors;
    int  idle_cycles;
    bit  no_gaps;       // last part of the run: no idling on either side
    bit  hold_sink;     // long back-pressure stretch requested
    int  hold_count;
    int  src_gap;
    int  snk_gap;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] note_table(int k);
        case (k)
            0: return 32'd8572947;   1: return 32'd9082720;
            2: return 32'd9622807;   3: return 32'd10195009;
            4: return 32'd10801236;  5: return 32'd11443511;
            6: return 32'd12123977;  7: return 32'd12844906;
            8: return 32'd13608704;  9: return 32'd14417920;
            10: return 32'd15275254; default: return 32'd16183568;
        endcase
    endfunction

    // Q15 sine magnitude of the LFO phase; sign comes back in neg.
    function automatic longint unsigned lfo_sine_mag(logic [15:0] ph, output bit neg);
        longint unsigned idx, q4, quad, z, z2, t;
        idx  = (longint'(ph) * SINE_DEPTH) >> 16;
        q4   = idx * 4;
        quad = (q4 / SINE_DEPTH) & 3;
        z    = (q4 % SINE_DEPTH) * 32768 / SINE_DEPTH;
        if (quad & 1) z = 32768 - z;
        neg = (quad >= 2);
        z2 = (z * z) >> 15;
        t  = 21024 - ((z2 * 2320) >> 15);
        t  = 51472 - ((z2 * t) >> 15);
        return (z * t) >> 15;
    endfunction

    function automatic void refresh_filter();
        longint unsigned c, r, d, s, mag;
        longint total;
        bit neg;
        c = clampv(cfg_cutoff, 0, 1024);
        r = clampv(cfg_reso, 0, 1024);
        d = clampv(cfg_depth, 0, 1024);
        s = lfo_sine_mag(v_phase, neg);
        mag = (s * d * c * 2000 + (64'd1 << 24)) >> 25;
        total = 102400 + c * 7900;
        total = neg ? total - longint'(mag) : total + longint'(mag);
        if (total < 102400) total = 102400;
        if (total > 8192000) total = 8192000;
        v_cutoff = 13'((total + 512) >> 10);
        v_q      = 13'((7168 + 43 * r + 5) / 10);
    endfunction

    task automatic voice_reset();
        cfg_cutoff = 307; cfg_reso = 307; cfg_rate = 338;
        cfg_depth = 768; cfg_detune = 65121;
        v_active = 0; v_release = 0; v_note = NO_NOTE; v_vel = 0;
        v_freq = 0; v_gain = 0; v_elapsed = 0; v_phase = 0; v_tick = 0;
        v_cutoff = 1000; v_q = 717;
    endtask

    // Advance the voice by one event and return the result it produces.
    function automatic mvrl_out_t voice_step(mvrl_in_t ev);
        mvrl_out_t o;
        longint unsigned t, det, ratio, peak, inc;
        peak = (4 * longint'(v_vel) + 2) / 5;
        case (ev.func)
            FUNC_NOTE_ON: begin
                if (ev.velocity != 0 && ev.velocity <= 1024) begin
                    t = longint'(note_table(ev.note % 12)) << (ev.note / 12);
                    v_active = 1; v_release = 0; v_elapsed = 0;
                    v_note = {1'b0, ev.note};
                    v_vel = ev.velocity;
                    v_freq = 18'((t + 32768) >> 16);
                    v_gain = 10'((4 * longint'(v_vel) + 2) / 5);
                end
            end
            FUNC_NOTE_OFF, FUNC_ALL_OFF: begin
                if (v_active && !v_release &&
                    (ev.func == FUNC_ALL_OFF || v_note == {1'b0, ev.note})) begin
                    v_release = 1; v_elapsed = 0;
                end
            end
            default: begin
                if (v_active && v_release) begin
                    if (v_elapsed <= REL_MS) v_elapsed++;
                    if (v_elapsed > REL_MS) begin
                        v_gain = 0; v_active = 0; v_release = 0; v_note = NO_NOTE;
                    end else begin
                        v_gain = 10'(peak * (REL_MS - v_elapsed) / REL_MS);
                    end
                end
                v_tick++;
                if (v_tick >= LFO_EVERY) begin
                    inc = (clampv(cfg_rate, 0, 10240) * LFO_EVERY * 64 + 500) / 1000;
                    v_tick = 0;
                    v_phase = 16'(v_phase + inc);
                    if (v_active) refresh_filter();
                end
            end
        endcase
        ratio = clampv(cfg_detune, 61858, 69433);
        det = (longint'(v_freq) * ratio + 32768) >> 16;
        if (det > 262143) det = 262143;
        o.main_freq    = v_freq;
        o.detuned_freq = 18'(det);
        o.sub_freq     = 17'(v_freq >> 1);
        o.amp_gain     = v_gain;
        o.cutoff_hz    = v_cutoff;
        o.filter_q     = v_q;
        o.voice_on     = v_active;
        o.in_release   = v_release;
        o.playing_note = v_note;
        return o;
    endfunction

    // Driver: present queued events, with random gaps unless told otherwise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                voice_results.push_back(voice_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_events.size() > 0 && !no_gaps &&
                             $urandom_range(0, 5) == 0) begin
                    s_valid <= 1'b0;
                    src_gap <= $urandom_range(0, 5);
                end else if (pending_events.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_events.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take result beats with random stalls and check each field.
    always @(posedge aclk) begin
        mvrl_out_t e;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            snk_gap    <= 0;
            hold_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (voice_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_data);
                    errors++;
                end else begin
                    e = voice_results.pop_front();
                    if (m_data.main_freq != e.main_freq)
                        $display("%0t: main_freq exp %0d got %0d", $time, e.main_freq,
                                 m_data.main_freq);
                    if (m_data.detuned_freq != e.detuned_freq)
                        $display("%0t: detuned_freq exp %0d got %0d", $time,
                                 e.detuned_freq, m_data.detuned_freq);
                    if (m_data.sub_freq != e.sub_freq)
                        $display("%0t: sub_freq exp %0d got %0d", $time, e.sub_freq,
                                 m_data.sub_freq);
                    if (m_data.amp_gain != e.amp_gain)
                        $display("%0t: amp_gain exp %0d got %0d", $time, e.amp_gain,
                                 m_data.amp_gain);
                    if (m_data.cutoff_hz != e.cutoff_hz)
                        $display("%0t: cutoff_hz exp %0d got %0d", $time, e.cutoff_hz,
                                 m_data.cutoff_hz);
                    if (m_data.filter_q != e.filter_q)
                        $display("%0t: filter_q exp %0d got %0d", $time, e.filter_q,
                                 m_data.filter_q);
                    if (m_data.voice_on != e.voice_on)
                        $display("%0t: voice_on exp %0d got %0d", $time, e.voice_on,
                                 m_data.voice_on);
                    if (m_data.in_release != e.in_release)
                        $display("%0t: in_release exp %0d got %0d", $time, e.in_release,
                                 m_data.in_release);
                    if (m_data.playing_note != e.playing_note)
                        $display("%0t: playing_note exp %0d got %0d", $time,
                                 e.playing_note, m_data.playing_note);
                    if (m_data != e) errors++;
                end
            end
            // Hold off for a long stretch on request, else random stall bursts.
            if (hold_sink && hold_count < 400) begin
                m_ready    <= 1'b0;
                hold_count <= hold_count + 1;
            end else if (snk_gap > 0) begin
                m_ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                snk_gap <= $urandom_range(0, 5);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any accepted beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (pending_events.size() > 0 || voice_results.size() > 0 || s_valid) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CUTOFF_BASE: cfg_cutoff = val[10:0];
            REG_RESONANCE:   cfg_reso   = val[10:0];
            REG_LFO_RATE:    cfg_rate   = val[13:0];
            REG_LFO_DEPTH:   cfg_depth  = val[10:0];
            default:         cfg_detune = val[16:0];
        endcase
    endtask

    // Wait until every expected beat has come, then let the sequencer settle.
    task automatic wait_drained();
        while (pending_events.size() > 0 || s_valid || voice_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic queue_event(logic [1:0] f, logic [6:0] n, logic [10:0] v);
        mvrl_in_t ev;
        ev.func = f; ev.note = n; ev.velocity = v;
        pending_events.push_back(ev);
    endtask

    // Random phrase: mostly note on / ticks / note off sequences, some noise.
    task automatic queue_phrase();
        logic [6:0] n;
        int k;
        n = 7'($urandom_range(0, 127));
        k = $urandom_range(0, 9);
        if (k == 0) begin
            queue_event(2'($urandom_range(0, 3)), 7'($urandom), 11'($urandom));
        end else begin
            queue_event(FUNC_NOTE_ON, n, 11'($urandom_range(1, 1024)));
            repeat ($urandom_range(0, 25)) queue_event(FUNC_TICK, 7'($urandom), 11'($urandom));
            if (k < 4) queue_event(FUNC_NOTE_OFF, 7'($urandom), 11'($urandom));
            if (k == 4) queue_event(FUNC_ALL_OFF, n, 11'($urandom));
            else queue_event(FUNC_NOTE_OFF, n, 11'($urandom));
            repeat ($urandom_range(0, 60)) queue_event(FUNC_TICK, 7'($urandom), 11'($urandom));
        end
    endtask

    task automatic random_config();
        apb_write(REG_CUTOFF_BASE, 32'($urandom_range(0, 2047)));
        apb_write(REG_RESONANCE,   32'($urandom_range(0, 2047)));
        apb_write(REG_LFO_RATE,    32'($urandom_range(0, 16383)));
        apb_write(REG_LFO_DEPTH,   32'($urandom_range(0, 2047)));
        apb_write(REG_DETUNE,      32'($urandom_range(0, 131071)));
    endtask

    initial begin
        int phase_n;
        errors = 0; no_gaps = 0; hold_sink = 0;
        aresetn = 1'b0;
        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        voice_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, bad velocities, foreign note off, release end.
        queue_event(FUNC_TICK, 7'd0, 11'd0);
        queue_event(FUNC_NOTE_OFF, 7'd60, 11'd0);
        queue_event(FUNC_NOTE_ON, 7'd69, 11'd0);
        queue_event(FUNC_NOTE_ON, 7'd69, 11'd1025);
        queue_event(FUNC_NOTE_ON, 7'd69, 11'd2047);
        queue_event(FUNC_NOTE_ON, 7'd127, 11'd1024);
        queue_event(FUNC_NOTE_ON, 7'd0, 11'd1);
        queue_event(FUNC_NOTE_OFF, 7'd127, 11'd0);
        queue_event(FUNC_NOTE_OFF, 7'd0, 11'h7FF);
        queue_event(FUNC_NOTE_OFF, 7'd0, 11'd0);
        queue_event(FUNC_NOTE_ON, 7'd127, 11'd1024);
        queue_event(FUNC_ALL_OFF, 7'd0, 11'd0);
        queue_event(FUNC_ALL_OFF, 7'd0, 11'd0);
        repeat (53) queue_event(FUNC_TICK, 7'h7F, 11'h7FF);
        queue_event(FUNC_NOTE_ON, 7'd60, 11'd512);
        queue_event(FUNC_NOTE_ON, 7'd64, 11'd700);
        wait_drained();

        // Extreme settings, including values above the clamp limits.
        apb_write(REG_CUTOFF_BASE, 32'd1024);
        apb_write(REG_RESONANCE,   32'd2047);
        apb_write(REG_LFO_RATE,    32'd16383);
        apb_write(REG_LFO_DEPTH,   32'd1024);
        apb_write(REG_DETUNE,      32'd131071);
        repeat (10) queue_phrase();
        wait_drained();

        apb_write(REG_CUTOFF_BASE, 32'd0);
        apb_write(REG_RESONANCE,   32'd0);
        apb_write(REG_LFO_RATE,    32'd0);
        apb_write(REG_LFO_DEPTH,   32'd0);
        apb_write(REG_DETUNE,      32'd0);
        repeat (5) queue_phrase();
        wait_drained();

        // Long back-pressure stretch while the sender keeps offering events.
        random_config();
        hold_sink = 1;
        repeat (7) queue_phrase();
        wait_drained();
        hold_sink = 0;

        for (phase_n = 0; phase_n < 5; phase_n++) begin
            random_config();
            if (phase_n == 4) no_gaps = 1;
            while (pending_events.size() < 160) queue_phrase();
            wait_drained();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
